/* src/atc_pkg.sv */
// Shared types and constants for the arithmetic token classifier.
// No dependencies; the recognizer, line state, top level and testbench import this package.
package atc_pkg;

    // Line limit: positions saturate at LINE_MAX - 1, the column count at LINE_MAX
    localparam int LINE_MAX = 256;
    localparam int COL_W    = $clog2(LINE_MAX + 1);
    localparam int POS_W    = 8;
    localparam int LEN_W    = 9;

    // Character codes
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // Word recognizer states; S_DEAD also stands for "no word yet"
    typedef enum logic [3:0] {
        S_DEAD   = 4'd0,
        S_INT    = 4'd1,
        S_DOT    = 4'd2,
        S_FRAC   = 4'd3,
        S_EXP    = 4'd4,
        S_ESIGN  = 4'd5,
        S_EXPD   = 4'd6,
        S_IDENT  = 4'd7,
        S_ASSIGN = 4'd8,
        S_PLUS   = 4'd9,
        S_MINUS  = 4'd10,
        S_TIMES  = 4'd11,
        S_POWER  = 4'd12,
        S_LPAR   = 4'd13,
        S_RPAR   = 4'd14,
        S_SLASH  = 4'd15
    } dfa_state_t;

    typedef enum logic [3:0] {
        CLS_INTEGER    = 4'd0,
        CLS_FLOAT      = 4'd1,
        CLS_ASSIGN     = 4'd2,
        CLS_PLUS       = 4'd3,
        CLS_MINUS      = 4'd4,
        CLS_TIMES      = 4'd5,
        CLS_DIVIDE     = 4'd6,
        CLS_POWER      = 4'd7,
        CLS_IDENTIFIER = 4'd8,
        CLS_LPAREN     = 4'd9,
        CLS_RPAREN     = 4'd10,
        CLS_COMMENT    = 4'd11
    } tok_class_t;

    typedef struct packed {
        tok_class_t         token_class;
        logic [POS_W-1:0]   start_column;
        logic [LEN_W-1:0]   token_length;
        logic               clipped;
    } token_t;

    typedef struct packed {
        logic   valid;
        token_t tok;
    } result_t;

endpackage

/* src/atc_char_if.sv */
// Character channel: valid/ready handshake carrying one byte of text.
// Depends on nothing.
interface atc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

/* src/atc_token_if.sv */
// Token channel: valid/ready handshake carrying one classified token.
// Depends on nothing.
interface atc_token_if;
    logic       valid;
    logic       ready;
    logic [3:0] token_class;
    logic [7:0] start_column;
    logic [8:0] token_length;
    logic       clipped;

    modport source (output valid, output token_class, output start_column,
                    output token_length, output clipped, input ready);
    modport sink   (input valid, input token_class, input start_column,
                    input token_length, input clipped, output ready);
endinterface

/* src/atc_dfa.sv */
// Word recognizer transition and class logic (purely combinational).
// Depends on atc_pkg.
module atc_dfa (
    input  atc_pkg::dfa_state_t cur_state,
    input  logic [7:0]          ch,
    output atc_pkg::dfa_state_t first_state,
    output atc_pkg::dfa_state_t next_state,
    output atc_pkg::tok_class_t cur_class,
    output logic                cur_match
);
    import atc_pkg::*;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_UNDER);
    endfunction

    // Pick the state for the first character of a word
    always_comb
    begin
        case (ch)
            CH_DOT:   first_state = S_DOT;
            CH_EQ:    first_state = S_ASSIGN;
            CH_PLUS:  first_state = S_PLUS;
            CH_MINUS: first_state = S_MINUS;
            CH_STAR:  first_state = S_TIMES;
            CH_CARET: first_state = S_POWER;
            CH_LPAR:  first_state = S_LPAR;
            CH_RPAR:  first_state = S_RPAR;
            CH_SLASH: first_state = S_SLASH;
            default:
            begin
                if (is_digit(ch))
                    first_state = S_INT;
                else if (is_alpha(ch))
                    first_state = S_IDENT;
                else
                    first_state = S_DEAD;
            end
        endcase
    end

    // Advance within a word; single-character tokens die on any extra byte
    always_comb
    begin
        case (cur_state)
            S_INT:
            begin
                if (is_digit(ch))
                    next_state = S_INT;
                else if (ch == CH_DOT)
                    next_state = S_DOT;
                else
                    next_state = S_DEAD;
            end
            S_DOT:
                next_state = is_digit(ch) ? S_FRAC : S_DEAD;
            S_FRAC:
            begin
                if (is_digit(ch))
                    next_state = S_FRAC;
                else if (ch == CH_E_UP || ch == CH_E_LO)
                    next_state = S_EXP;
                else
                    next_state = S_DEAD;
            end
            S_EXP:
            begin
                if (is_digit(ch))
                    next_state = S_EXPD;
                else if (ch == CH_PLUS || ch == CH_MINUS)
                    next_state = S_ESIGN;
                else
                    next_state = S_DEAD;
            end
            S_ESIGN, S_EXPD:
                next_state = is_digit(ch) ? S_EXPD : S_DEAD;
            S_IDENT:
                next_state = (is_alpha(ch) || is_digit(ch)) ? S_IDENT : S_DEAD;
            default:
                next_state = S_DEAD;
        endcase
    end

    // Map accepting states to token classes
    always_comb
    begin
        cur_match = 1'b1;
        case (cur_state)
            S_INT:          cur_class = CLS_INTEGER;
            S_FRAC, S_EXPD: cur_class = CLS_FLOAT;
            S_ASSIGN:       cur_class = CLS_ASSIGN;
            S_PLUS:         cur_class = CLS_PLUS;
            S_MINUS:        cur_class = CLS_MINUS;
            S_TIMES:        cur_class = CLS_TIMES;
            S_SLASH:        cur_class = CLS_DIVIDE;
            S_POWER:        cur_class = CLS_POWER;
            S_IDENT:        cur_class = CLS_IDENTIFIER;
            S_LPAR:         cur_class = CLS_LPAREN;
            S_RPAR:         cur_class = CLS_RPAREN;
            default:
            begin
                cur_class = CLS_INTEGER;
                cur_match = 1'b0;
            end
        endcase
    end

endmodule

/* src/atc_line_state.sv */
// Per-line lexer state: column tracking, word and comment bookkeeping, token build.
// Depends on atc_pkg and atc_dfa.
module atc_line_state (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          ch,
    output atc_pkg::result_t    result
);
    import atc_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] word_start_reg, word_start_next;
    logic             in_word_reg, in_word_next;
    dfa_state_t       dfa_reg, dfa_next;
    logic             in_comment_reg, in_comment_next;
    logic [POS_W-1:0] fds_reg, fds_next;
    logic             dss_reg, dss_next;
    logic             pws_reg, pws_next;
    logic             ovf_reg, ovf_next;

    dfa_state_t first_state, next_state;
    tok_class_t cur_class;
    logic       cur_match;

    logic             is_nl, is_sep, is_slash, sat, ovf_upd, word_hit, opens_comment;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] word_len, comment_len;

    atc_dfa u_dfa (
        .cur_state   (dfa_reg),
        .ch          (ch),
        .first_state (first_state),
        .next_state  (next_state),
        .cur_class   (cur_class),
        .cur_match   (cur_match)
    );

    // Decode the byte and the saturated position
    always_comb
    begin
        is_nl    = (ch == CH_NL);
        is_sep   = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        is_slash = (ch == CH_SLASH);
        sat      = (col_reg >= COL_W'(LINE_MAX));
        pos      = sat ? POS_W'(LINE_MAX - 1) : col_reg[POS_W-1:0];
        ovf_upd  = ovf_reg | sat;
        word_hit = in_word_reg && !in_comment_reg && cur_match;
        word_len    = LEN_W'(col_reg) - LEN_W'(word_start_reg);
        comment_len = LEN_W'(col_reg) - LEN_W'(fds_reg);
        opens_comment = (dfa_reg == S_SLASH) && is_slash &&
                        ({1'b0, pos} == ({1'b0, word_start_reg} + 1'b1));
    end

    // Build the token for this byte, if any
    always_comb
    begin
        result                  = '0;
        result.tok.token_class  = cur_class;
        result.tok.start_column = word_start_reg;
        result.tok.token_length = word_len;
        result.tok.clipped      = ovf_upd;
        if (is_nl)
        begin
            result.tok.clipped = ovf_reg;
            if (in_comment_reg)
            begin
                result.valid            = step;
                result.tok.token_class  = CLS_COMMENT;
                result.tok.start_column = fds_reg;
                result.tok.token_length = comment_len;
            end
            else
            begin
                result.valid = step && word_hit;
            end
        end
        else
        begin
            result.valid = step && is_sep && word_hit;
        end
    end

    // Next state: a newline clears the line, other bytes advance it
    always_comb
    begin
        col_next        = col_reg;
        word_start_next = word_start_reg;
        in_word_next    = in_word_reg;
        dfa_next        = dfa_reg;
        in_comment_next = in_comment_reg;
        fds_next        = fds_reg;
        dss_next        = dss_reg;
        pws_next        = pws_reg;
        ovf_next        = ovf_reg;
        if (step)
        begin
            if (is_nl)
            begin
                col_next        = '0;
                word_start_next = '0;
                in_word_next    = 1'b0;
                dfa_next        = S_DEAD;
                in_comment_next = 1'b0;
                fds_next        = '0;
                dss_next        = 1'b0;
                pws_next        = 1'b0;
                ovf_next        = 1'b0;
            end
            else
            begin
                ovf_next = ovf_upd;
                // Record the first double slash of the line
                if (is_slash && pws_reg && !dss_reg)
                begin
                    dss_next = 1'b1;
                    fds_next = pos - 1'b1;
                end
                pws_next = is_slash;
                if (is_sep)
                begin
                    in_word_next = 1'b0;
                end
                else if (!in_comment_reg)
                begin
                    if (!in_word_reg)
                    begin
                        in_word_next    = 1'b1;
                        word_start_next = pos;
                        dfa_next        = first_state;
                    end
                    else if (opens_comment)
                    begin
                        in_comment_next = 1'b1;
                        dfa_next        = S_DEAD;
                    end
                    else
                    begin
                        dfa_next = next_state;
                    end
                end
                if (!sat)
                    col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            word_start_reg <= '0;
            in_word_reg    <= 1'b0;
            dfa_reg        <= S_DEAD;
            in_comment_reg <= 1'b0;
            fds_reg        <= '0;
            dss_reg        <= 1'b0;
            pws_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            word_start_reg <= word_start_next;
            in_word_reg    <= in_word_next;
            dfa_reg        <= dfa_next;
            in_comment_reg <= in_comment_next;
            fds_reg        <= fds_next;
            dss_reg        <= dss_next;
            pws_reg        <= pws_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

/* src/arithmetic_token_classifier.sv */
// Arithmetic token classifier, top level.
// Depends on atc_pkg, atc_char_if, atc_token_if and atc_line_state.
//
// Usage:
//   chars  - sink of one text byte per transfer (valid/ready).
//   tokens - source of classified tokens: class, start column, length and a
//            clipped flag; one token at most per byte.
//   Words end at whitespace or newline; a token appears for the byte that ends
//   a recognized word, and a comment token appears for the newline of a line
//   that holds one. Other bytes produce no transfer on tokens.
// Path: the byte that ends a token is captured in the input register, and the
//   token is then offered from the result register.
// Throughput: one byte per clock while no token waits with tokens.ready low;
//   the line state logic is combinational between the input and result registers.
// Stall: while a token waits in the result register and tokens.ready is low,
//   the next byte waits in the input register and chars.ready drops.
// Reset: rst_n clears the valid flags of both registers and the line state
//   (column zero, no word open, no comment).
module arithmetic_token_classifier (
    input  logic              clk,
    input  logic              rst_n,
    atc_char_if.sink          chars,
    atc_token_if.source       tokens
);
    import atc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       out_valid_reg;
    token_t     out_tok_reg;
    logic       advance;
    result_t    result;

    // Process the held byte when the result register can take its outcome
    assign advance      = in_valid_reg && (!out_valid_reg || tokens.ready);
    assign chars.ready  = !in_valid_reg || advance;

    atc_line_state u_line (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ch     (in_char_reg),
        .result (result)
    );

    // Input register: hold the byte until it is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (chars.ready)
            in_valid_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
            in_char_reg <= chars.character;
    end

    // Result register: load on advance, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= result.valid;
        else if (tokens.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
            out_tok_reg <= result.tok;
    end

    assign tokens.valid        = out_valid_reg;
    assign tokens.token_class  = out_tok_reg.token_class;
    assign tokens.start_column = out_tok_reg.start_column;
    assign tokens.token_length = out_tok_reg.token_length;
    assign tokens.clipped      = out_tok_reg.clipped;

`ifndef SYNTHESIS
    // A stalled byte stays in the input register
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !tokens.ready
        |=> in_valid_reg && $stable(in_char_reg))
        else $error("input byte lost during output stall");

    // Back-pressure only comes from a waiting token
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !chars.ready |-> out_valid_reg && !tokens.ready && in_valid_reg)
        else $error("chars.ready low without a stalled token");

    // A token never runs past the line limit
    a_token_span: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid |-> (tokens.token_length != 9'd0) &&
        (({2'b00, tokens.start_column} + {1'b0, tokens.token_length})
            <= 10'(LINE_MAX)))
        else $error("token extends past the line limit");
`endif

endmodule

/* dv/tb_arithmetic_token_classifier.sv */
`timescale 1ns / 100ps
// Testbench for arithmetic_token_classifier: streams text lines, predicts every token and
// checks each one field by field. Depends on atc_pkg, atc_char_if, atc_token_if and the RTL.
module tb_arithmetic_token_classifier;
    import atc_pkg::*;

    localparam int          RANDOM_CHARS = 1500;
    localparam int          CALM_TAIL    = 150;
    localparam int          LONG_HOLD    = 80;
    localparam int          TIMEOUT_NS   = 500000;
    localparam logic [7:0]  CH_VT        = 8'd11;
    localparam logic [7:0]  CH_FF        = 8'd12;

    typedef struct {
        logic [7:0] ch;
        bit         drain;
    } char_item_t;

    logic clk;
    logic rst_n;

    atc_char_if  char_bus ();
    atc_token_if token_bus ();

    arithmetic_token_classifier uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (char_bus),
        .tokens (token_bus)
    );

    // Text waiting to be sent and tokens waiting to come out
    char_item_t pending_chars[$];
    token_t     expected_tokens[$];

    // Line state of the token predictor
    int         line_col;
    int         word_begin;
    int         comment_col;
    bit         word_open;
    bit         comment_open;
    bit         comment_found;
    bit         last_slash;
    bit         line_clipped;
    dfa_state_t word_state;

    // Stimulus bookkeeping
    string ident_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string ident_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    int    line_len;
    int    lines_made;
    int    long_lines;
    bit    drain_next;
    int    total_chars;

    // Handshake and checking counters
    int chars_sent;
    int tokens_checked;
    int mismatches;
    int class_seen[16];
    bit char_taken;
    int send_gap;
    int recv_gap;
    int send_idle_pct;
    int recv_idle_pct;
    int long_hold_left;
    int long_holds_done;

    // ------------------------------------------------------------------
    // Character classes and word recognizer
    // ------------------------------------------------------------------
    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER;
    endfunction

    function automatic bit is_sep(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic dfa_state_t word_first(logic [7:0] c);
        if (is_digit(c))
            return S_INT;
        if (c == CH_DOT)
            return S_DOT;
        if (is_letter(c))
            return S_IDENT;
        case (c)
            CH_EQ:    return S_ASSIGN;
            CH_PLUS:  return S_PLUS;
            CH_MINUS: return S_MINUS;
            CH_STAR:  return S_TIMES;
            CH_CARET: return S_POWER;
            CH_LPAR:  return S_LPAR;
            CH_RPAR:  return S_RPAR;
            CH_SLASH: return S_SLASH;
            default:  return S_DEAD;
        endcase
    endfunction

    function automatic dfa_state_t word_next(dfa_state_t s, logic [7:0] c);
        case (s)
            S_INT:
                if (is_digit(c))
                    return S_INT;
                else
                    return (c == CH_DOT) ? S_DOT : S_DEAD;
            S_DOT:
                return is_digit(c) ? S_FRAC : S_DEAD;
            S_FRAC:
                if (is_digit(c))
                    return S_FRAC;
                else
                    return (c == CH_E_LO || c == CH_E_UP) ? S_EXP : S_DEAD;
            S_EXP:
                if (is_digit(c))
                    return S_EXPD;
                else
                    return (c == CH_PLUS || c == CH_MINUS) ? S_ESIGN : S_DEAD;
            S_ESIGN, S_EXPD:
                return is_digit(c) ? S_EXPD : S_DEAD;
            S_IDENT:
                return (is_letter(c) || is_digit(c)) ? S_IDENT : S_DEAD;
            default:
                return S_DEAD;
        endcase
    endfunction

    // Map an accepting recognizer state to its class; return 0 for a dropped word
    function automatic bit word_class(dfa_state_t s, output tok_class_t cls);
        word_class = 1'b1;
        case (s)
            S_INT:         cls = CLS_INTEGER;
            S_FRAC, S_EXPD: cls = CLS_FLOAT;
            S_ASSIGN:      cls = CLS_ASSIGN;
            S_PLUS:        cls = CLS_PLUS;
            S_MINUS:       cls = CLS_MINUS;
            S_TIMES:       cls = CLS_TIMES;
            S_SLASH:       cls = CLS_DIVIDE;
            S_POWER:       cls = CLS_POWER;
            S_IDENT:       cls = CLS_IDENTIFIER;
            S_LPAR:        cls = CLS_LPAREN;
            S_RPAR:        cls = CLS_RPAREN;
            default:
            begin
                cls = CLS_INTEGER;
                word_class = 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    task automatic record_token(tok_class_t cls, int start, int len);
        token_t t;
        t.token_class  = cls;
        t.start_column = POS_W'(start);
        t.token_length = LEN_W'(len);
        t.clipped      = line_clipped;
        expected_tokens = {expected_tokens, t};
    endtask

    task automatic close_word();
        tok_class_t cls;
        if (word_open && !comment_open && word_class(word_state, cls))
            record_token(cls, word_begin, line_col - word_begin);
    endtask

    task automatic clear_line();
        line_col      = 0;
        word_begin    = 0;
        comment_col   = 0;
        word_open     = 1'b0;
        comment_open  = 1'b0;
        comment_found = 1'b0;
        last_slash    = 1'b0;
        line_clipped  = 1'b0;
        word_state    = S_DEAD;
    endtask

    task automatic predict_char(logic [7:0] ch);
        int pos;
        // Newline: flush the comment or the open word, then start a fresh line
        if (ch == CH_NL)
        begin
            if (comment_open)
                record_token(CLS_COMMENT, comment_col, line_col - comment_col);
            else
                close_word();
            clear_line();
            return;
        end

        // Saturate the position once the line runs past the limit
        if (line_col >= LINE_MAX)
        begin
            line_clipped = 1'b1;
            pos = LINE_MAX - 1;
        end
        else
        begin
            pos = line_col;
        end

        // Remember the first double slash anywhere in the line
        if (ch == CH_SLASH && last_slash && !comment_found)
        begin
            comment_found = 1'b1;
            comment_col   = pos - 1;
        end
        last_slash = (ch == CH_SLASH);

        if (is_sep(ch))
        begin
            close_word();
            word_open = 1'b0;
        end
        else if (!comment_open)
        begin
            if (!word_open)
            begin
                word_open  = 1'b1;
                word_begin = pos;
                word_state = word_first(ch);
            end
            else if (word_state == S_SLASH && ch == CH_SLASH && pos == word_begin + 1)
            begin
                comment_open = 1'b1;
                word_state   = S_DEAD;
            end
            else
            begin
                word_state = word_next(word_state, ch);
            end
        end

        if (line_col < LINE_MAX)
            line_col++;
    endtask

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------
    task automatic push_byte(logic [7:0] c);
        char_item_t it;
        it.ch      = c;
        it.drain   = drain_next;
        drain_next = 1'b0;
        pending_chars = {pending_chars, it};
        line_len++;
        if (c == CH_NL)
            lines_made++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_seps(int n);
        repeat (n)
        begin
            case ($urandom_range(7))
                4:       push_byte(CH_TAB);
                5:       push_byte(CH_VT);
                6:       push_byte(CH_FF);
                7:       push_byte(CH_CR);
                default: push_byte(CH_SPACE);
            endcase
        end
    endtask

    task automatic push_digits(int n);
        repeat (n)
            push_byte("0" + 8'($urandom_range(9)));
    endtask

    task automatic push_ident(int tail_len);
        push_byte(ident_head[$urandom_range(ident_head.len() - 1)]);
        repeat (tail_len)
            push_byte(ident_tail[$urandom_range(ident_tail.len() - 1)]);
    endtask

    function automatic logic [7:0] op_char(int k);
        case (k)
            0:       return CH_EQ;
            1:       return CH_PLUS;
            2:       return CH_MINUS;
            3:       return CH_STAR;
            4:       return CH_SLASH;
            5:       return CH_CARET;
            6:       return CH_LPAR;
            default: return CH_RPAR;
        endcase
    endfunction

    // Any byte that stays inside a word
    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_sep(c));
        return c;
    endfunction

    // Any byte short of a newline
    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_NL);
        return c;
    endfunction

    task automatic push_exponent();
        push_byte($urandom_range(1) ? CH_E_LO : CH_E_UP);
        case ($urandom_range(2))
            0: push_byte(CH_PLUS);
            1: push_byte(CH_MINUS);
            default: ;
        endcase
        push_digits($urandom_range(3, 1));
    endtask

    task automatic add_word();
        case ($urandom_range(15))
            0, 1:
                push_digits($urandom_range(6, 1));
            2, 3:
            begin
                push_digits($urandom_range(3));
                push_byte(CH_DOT);
                push_digits($urandom_range(4, 1));
                if ($urandom_range(1))
                    push_exponent();
            end
            4, 5, 6:
                push_byte(op_char($urandom_range(7)));
            7, 8, 9:
                push_ident($urandom_range(7));
            10:
            begin
                // Float cut short: trailing dot, bare exponent or sign
                push_digits($urandom_range(2));
                push_byte(CH_DOT);
                if ($urandom_range(1))
                begin
                    push_digits($urandom_range(2, 1));
                    push_byte(CH_E_LO);
                    if ($urandom_range(1))
                        push_byte(CH_MINUS);
                end
            end
            11:
            begin
                // Valid word spoiled by one arbitrary byte
                if ($urandom_range(1))
                    push_ident($urandom_range(4));
                else
                    push_digits($urandom_range(4, 1));
                push_byte(word_byte());
            end
            12, 13:
                repeat ($urandom_range(4, 1))
                    push_byte(word_byte());
            14:
            begin
                // Slashes inside or at the head of a word
                case ($urandom_range(2))
                    0:
                    begin
                        push_ident($urandom_range(3));
                        push_text("//");
                        push_ident($urandom_range(3));
                    end
                    1:
                    begin
                        push_byte(CH_SLASH);
                        push_ident(0);
                    end
                    default:
                        push_text("///");
                endcase
            end
            default:
            begin
                push_byte(op_char($urandom_range(7)));
                push_byte(op_char($urandom_range(7)));
            end
        endcase
    endtask

    task automatic add_comment(int body_len);
        push_text("//");
        repeat (body_len)
            push_byte(text_byte());
    endtask

    task automatic add_long_line();
        int target;
        target = $urandom_range(330, 262);
        long_lines++;
        case ($urandom_range(2))
            0:
            begin
                while (line_len < target)
                begin
                    add_word();
                    push_seps(1);
                end
            end
            1:
                push_ident($urandom_range(300, 255));
            default:
            begin
                repeat (3)
                begin
                    add_word();
                    push_seps(1);
                end
                add_comment(0);
                while (line_len < target)
                    push_byte(text_byte());
            end
        endcase
    endtask

    task automatic add_line();
        int words;
        line_len = 0;
        case ($urandom_range(29))
            0:
                ;
            1:
                push_seps($urandom_range(4, 1));
            2:
                add_long_line();
            default:
            begin
                if ($urandom_range(3) == 0)
                    push_seps($urandom_range(2, 1));
                words = $urandom_range(7);
                for (int i = 0; i < words; i++)
                begin
                    if (i != 0)
                        push_seps($urandom_range(3) == 0 ? 2 : 1);
                    add_word();
                end
                if ($urandom_range(5) == 0)
                begin
                    if (words != 0)
                        push_seps(1);
                    add_comment($urandom_range(15));
                end
                else if ($urandom_range(3) == 0)
                begin
                    push_seps($urandom_range(2, 1));
                end
            end
        endcase
        push_byte(CH_NL);
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n               = 1'b0;
        char_bus.valid      = 1'b0;
        char_bus.character  = '0;
        token_bus.ready     = 1'b0;
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        clear_line();

        // Directed lines: float, operators, identifier at newline, comment
        // that starts inside an earlier word
        push_text("1.5e-3 + * ( x_9\n");
        push_text("a//b //c\n");

        // Random lines; pause for a full drain right after the directed part
        // and again midway
        drain_next = 1'b1;
        while (pending_chars.size() < 26 + RANDOM_CHARS)
        begin
            if (pending_chars.size() >= 800 && pending_chars.size() < 840)
                drain_next = 1'b1;
            add_line();
        end
        total_chars = pending_chars.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (chars_sent < total_chars)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d characters in %0d lines (%0d past the column limit); checked %0d tokens",
                 chars_sent, lines_made, long_lines, tokens_checked);
        $display("Tokens by class: int %0d float %0d ops %0d ident %0d parens %0d comment %0d",
                 class_seen[CLS_INTEGER], class_seen[CLS_FLOAT],
                 class_seen[CLS_ASSIGN] + class_seen[CLS_PLUS] + class_seen[CLS_MINUS]
                 + class_seen[CLS_TIMES] + class_seen[CLS_DIVIDE] + class_seen[CLS_POWER],
                 class_seen[CLS_IDENTIFIER], class_seen[CLS_LPAREN] + class_seen[CLS_RPAREN],
                 class_seen[CLS_COMMENT]);
        if (mismatches == 0)
            $display("tb_arithmetic_token_classifier passed");
        else
            $display("tb_arithmetic_token_classifier failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout at %0t with %0d of %0d characters sent, %0d tokens outstanding",
                 $time, chars_sent, total_chars, expected_tokens.size());
        $display("tb_arithmetic_token_classifier failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Character side: predict on each transfer, drive on the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        char_taken = 1'b0;
        if (rst_n && char_bus.valid && char_bus.ready)
        begin
            predict_char(char_bus.character);
            chars_sent++;
            char_taken = 1'b1;
            // Reshuffle idling every so often, leaving some stretches without any
            if (chars_sent % 128 == 0)
            begin
                send_idle_pct = pick_idle_pct();
                recv_idle_pct = pick_idle_pct();
            end
        end
    end

    always @(negedge clk)
    begin : char_driver
        char_item_t item;
        if (!rst_n)
        begin
            char_bus.valid <= 1'b0;
        end
        else if (!char_bus.valid || char_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                char_bus.valid <= 1'b0;
            end
            else if (pending_chars.size() == 0
                     || (pending_chars[0].drain && expected_tokens.size() != 0))
            begin
                char_bus.valid <= 1'b0;
            end
            else
            begin
                item = pending_chars.pop_front();
                char_bus.valid     <= 1'b1;
                char_bus.character <= item.ch;
                if (pending_chars.size() >= CALM_TAIL && $urandom_range(99) < send_idle_pct)
                    send_gap = $urandom_range(11, 1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Token side: stall the receiver, check each transfer
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            token_bus.ready <= 1'b0;
        end
        else if (long_hold_left > 0)
        begin
            long_hold_left--;
            token_bus.ready <= 1'b0;
        end
        else if (long_holds_done < 2 && chars_sent >= 400 + 600 * long_holds_done)
        begin
            // Hold off long enough for the block to back up into its input
            long_holds_done++;
            long_hold_left = LONG_HOLD - 1;
            token_bus.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            token_bus.ready <= 1'b0;
        end
        else if (pending_chars.size() >= CALM_TAIL && $urandom_range(99) < recv_idle_pct)
        begin
            recv_gap = $urandom_range(10);
            token_bus.ready <= 1'b0;
        end
        else
        begin
            token_bus.ready <= 1'b1;
        end
    end

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: token %0d %s expected %0d actual %0d",
                     $time, tokens_checked, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : token_check
        token_t want;
        if (rst_n && token_bus.valid && token_bus.ready)
        begin
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no token, actual class %0d start %0d length %0d clipped %0d",
                         $time, token_bus.token_class, token_bus.start_column,
                         token_bus.token_length, token_bus.clipped);
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_class", want.token_class, token_bus.token_class);
                check_field("start_column", want.start_column, token_bus.start_column);
                check_field("token_length", want.token_length, token_bus.token_length);
                check_field("clipped", want.clipped, token_bus.clipped);
                class_seen[want.token_class]++;
            end
            tokens_checked++;
        end
    end

endmodule
